@@ rtl/core/mhw_pkg.sv @@
// ----------------------------------------------------------------------------
// mhw_pkg
// shared widths, codes and types of the multilevel haar wavelet block
// ----------------------------------------------------------------------------
package mhw_pkg;

    localparam int MAX_LEVELS     = 8;
    localparam int MAX_BLOCK_LOG2 = 16;
    localparam int SAMPLE_WIDTH   = 16;

    localparam int COEF_W   = 24;
    localparam int LVL_W    = 4;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = MAX_BLOCK_LOG2 + 1;

    // stream widths, whole bytes
    localparam int S_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_FIELD_W = COEF_W + LVL_W + POS_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1 + STATUS_W;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVELS   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_INT_MODE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVF = 2'd2;

    // 1/sqrt2 in q1.15
    localparam int INV_SQRT2_Q15 = 23170;

    // value walking down the chain of levels
    typedef struct packed {
        logic                     vld;
        logic signed [COEF_W-1:0] val;
        logic [POS_W-1:0]         pos;
    } tok_t;

    // per-level status seen by the controller
    typedef struct packed {
        logic in_vld;
        logic pend_vld;
    } cell_stat_t;

endpackage

@@ rtl/core/mhw_cell.sv @@
// ----------------------------------------------------------------------------
// mhw_cell
// one decomposition level: holds the pending value, pairs it with the
// arriving value and hands the approximation to the next level
// ----------------------------------------------------------------------------
module mhw_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic                               clr,
    input  logic                               int_mode,
    input  mhw_pkg::tok_t                      tok_in,
    output mhw_pkg::tok_t                      tok_out,
    output logic signed [mhw_pkg::COEF_W-1:0]  det_coef,
    output mhw_pkg::cell_stat_t                stat
);
    import mhw_pkg::*;

    localparam int SUM_W  = COEF_W + 1;
    localparam int KQ_W   = 16;
    localparam int PROD_W = SUM_W + KQ_W;
    localparam logic signed [PROD_W-1:0] CMAX = PROD_W'((2 ** (COEF_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] CMIN = -PROD_W'(2 ** (COEF_W - 1));
    localparam logic signed [PROD_W-1:0] RND  = PROD_W'(2 ** 14);
    localparam logic signed [KQ_W-1:0]   KQ   = KQ_W'(INV_SQRT2_Q15);

    function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [PROD_W-1:0] v);
        logic signed [COEF_W-1:0] r;
        if (v > CMAX) begin
            r = CMAX[COEF_W-1:0];
        end else if (v < CMIN) begin
            r = CMIN[COEF_W-1:0];
        end else begin
            r = v[COEF_W-1:0];
        end
        return r;
    endfunction

    logic                     in_vld_reg;
    logic signed [COEF_W-1:0] in_val_reg;
    logic [POS_W-1:0]         in_pos_reg;
    logic                     pend_vld_reg;
    logic signed [COEF_W-1:0] pend_reg;

    logic                     act;
    logic                     pair;
    logic signed [SUM_W-1:0]  sum_v;
    logic signed [SUM_W-1:0]  dif_v;
    logic signed [PROD_W-1:0] prod_a;
    logic signed [PROD_W-1:0] prod_d;
    logic signed [PROD_W-1:0] lift_a;
    logic signed [COEF_W-1:0] a_val;
    logic signed [COEF_W-1:0] d_val;

    assign act  = in_vld_reg & adv;
    assign pair = act & pend_vld_reg;

    always_comb begin
        sum_v  = SUM_W'(pend_reg) + SUM_W'(in_val_reg);
        dif_v  = SUM_W'(in_val_reg) - SUM_W'(pend_reg);
        prod_a = PROD_W'(sum_v) * PROD_W'(KQ);
        prod_d = PROD_W'(dif_v) * PROD_W'(KQ);
        // lifting: a = x0 + floor(d/2)
        lift_a = PROD_W'(pend_reg) + PROD_W'(dif_v >>> 1);
        if (int_mode) begin
            a_val = sat_coef(lift_a);
            d_val = sat_coef(PROD_W'(dif_v));
        end else begin
            a_val = sat_coef((prod_a + RND) >>> 15);
            d_val = sat_coef((prod_d + RND) >>> 15);
        end
    end

    assign tok_out.vld   = pair;
    assign tok_out.val   = a_val;
    assign tok_out.pos   = {1'b0, in_pos_reg[POS_W-1:1]};
    assign det_coef      = d_val;
    assign stat.in_vld   = in_vld_reg;
    assign stat.pend_vld = pend_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
        end else begin
            if (adv || !in_vld_reg) begin
                in_vld_reg <= tok_in.vld;
            end
            if (clr) begin
                pend_vld_reg <= 1'b0;
            end else if (act) begin
                pend_vld_reg <= !pend_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv || !in_vld_reg) begin
            in_val_reg <= tok_in.val;
            in_pos_reg <= tok_in.pos;
        end
        if (act && !pend_vld_reg) begin
            pend_reg <= in_val_reg;
        end
    end

endmodule

@@ rtl/core/multilevel_haar_wavelet_top.sv @@
// ----------------------------------------------------------------------------
// multilevel_haar_wavelet_top
// streaming multi-level 1-d haar transform over blocks of samples
// ----------------------------------------------------------------------------
// Each sample enters a chain of level cells and walks down it one cell per
// cycle unless the chain is stalled: a cell that is empty keeps the value, a
// full cell emits a detail word and passes the approximation on; past the last
// configured level the final approximation is emitted. Only one sample is in
// the chain at a time. A sample that comes to rest at level j (1-based) is
// accepted and passes cells 1 to j; one that runs through all L levels passes
// the accept step, the L cells and the approximation register, and an error
// word at the end of a block follows. Result words stall the whole chain while
// the output register is full and m_tready is low. The user must write levels
// and the mode bit through the cfg_ port only while the block is idle; the
// block itself does not enforce this. Levels of 0 act as 1, above 8 as 8.
// ----------------------------------------------------------------------------
module multilevel_haar_wavelet_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [mhw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mhw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // sample words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mhw_pkg::S_TDATA_W-1:0]     s_tdata,   // sample[15:0]
    input  logic                              s_tlast,   // end_of_block
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mhw_pkg::M_TDATA_W-1:0]     m_tdata,   // coefficient[23:0], level[27:24], position[43:28], zero pad
    output logic [mhw_pkg::M_TUSER_W-1:0]     m_tuser,   // is_detail[0], status[2:1]
    output logic                              m_tlast    // last_of_run
);
    import mhw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(2 ** MAX_BLOCK_LOG2);

    // configuration registers
    logic [LVL_W-1:0] levels_reg;
    logic             int_mode_reg;
    logic [LVL_W-1:0] l_eff;

    // control
    logic [1:0]          state_reg,  state_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic                eob_reg,    eob_next;
    logic [STATUS_W-1:0] err_reg,    err_next;
    logic                clr_blk;
    logic                inj_vld;
    logic                adv;
    logic                store_now;
    logic                done_now;
    logic                any_pend;

    // chain of level cells
    tok_t                     tok_in   [MAX_LEVELS];
    tok_t                     tok_out  [MAX_LEVELS];
    logic signed [COEF_W-1:0] det_coef [MAX_LEVELS];
    cell_stat_t               stat     [MAX_LEVELS];
    logic [MAX_LEVELS-1:0]    lvl_last;
    logic [MAX_LEVELS-1:0]    in_vld_v;
    logic [MAX_LEVELS:0]      pend_ext;
    logic                     apx_load;

    // final approximation stage
    logic                     apx_vld_reg;
    logic signed [COEF_W-1:0] apx_val_reg;
    logic [POS_W-1:0]         apx_pos_reg;
    logic signed [COEF_W-1:0] apx_val_next;
    logic [POS_W-1:0]         apx_pos_next;

    // result selected this cycle
    logic                     res_vld;
    logic signed [COEF_W-1:0] res_coef;
    logic [LVL_W-1:0]         res_lvl;
    logic                     res_det;
    logic [POS_W-1:0]         res_pos;
    logic [STATUS_W-1:0]      res_status;
    logic                     res_last;

    // output register
    logic                     m_vld_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;
    logic [M_TUSER_W-1:0]     m_user_reg;
    logic                     m_last_reg;

    // effective level count
    always_comb begin
        if (levels_reg == '0) begin
            l_eff = LVL_W'(1);
        end else if (levels_reg > LVL_W'(MAX_LEVELS)) begin
            l_eff = LVL_W'(MAX_LEVELS);
        end else begin
            l_eff = levels_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg   <= LVL_W'(1);
            int_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_LEVELS:   levels_reg   <= cfg_wdata[LVL_W-1:0];
                REG_INT_MODE: int_mode_reg <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // chain advances whenever the output register can take a word
    assign adv = !m_vld_reg || m_tready;

    // cell 0 takes the sample, cell k+1 takes what cell k passes unless k is last
    always_comb begin
        for (int k = 0; k < MAX_LEVELS; k++) begin
            lvl_last[k] = (LVL_W'(k + 1) == l_eff);
            in_vld_v[k] = stat[k].in_vld;
            pend_ext[k] = stat[k].pend_vld;
        end
        // nothing beyond the deepest cell takes a value
        pend_ext[MAX_LEVELS] = 1'b1;
        tok_in[0].vld = inj_vld;
        tok_in[0].val = COEF_W'($signed(s_tdata[SAMPLE_WIDTH-1:0]));
        tok_in[0].pos = cnt_reg[POS_W-1:0];
        for (int k = 1; k < MAX_LEVELS; k++) begin
            tok_in[k].vld = tok_out[k-1].vld & !lvl_last[k-1];
            tok_in[k].val = tok_out[k-1].val;
            tok_in[k].pos = tok_out[k-1].pos;
        end
    end

    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
        mhw_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .clr      (clr_blk),
            .int_mode (int_mode_reg),
            .tok_in   (tok_in[g]),
            .tok_out  (tok_out[g]),
            .det_coef (det_coef[g]),
            .stat     (stat[g])
        );
    end

    // approximation leaving the last configured level
    always_comb begin
        apx_load     = 1'b0;
        apx_val_next = apx_val_reg;
        apx_pos_next = apx_pos_reg;
        for (int k = 0; k < MAX_LEVELS; k++) begin
            if (tok_out[k].vld && lvl_last[k]) begin
                apx_load     = 1'b1;
                apx_val_next = tok_out[k].val;
                apx_pos_next = tok_out[k].pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            apx_vld_reg <= 1'b0;
        end else if (adv || !apx_vld_reg) begin
            apx_vld_reg <= apx_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv || !apx_vld_reg) begin
            apx_val_reg <= apx_val_next;
            apx_pos_reg <= apx_pos_next;
        end
    end

    // the sample comes to rest in an empty cell, or leaves as approximation
    assign store_now = |(in_vld_v & ~pend_ext[MAX_LEVELS-1:0]);
    assign done_now  = adv && (store_now || apx_vld_reg);
    assign any_pend  = |pend_ext[MAX_LEVELS-1:0];

    // block controller
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        eob_next   = eob_reg;
        err_next   = err_reg;
        clr_blk    = 1'b0;
        inj_vld    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (cnt_reg[MAX_BLOCK_LOG2]) begin
                        // block too long, sample dropped
                        cnt_next = LIMIT + CNT_W'(1);
                        if (s_tlast) begin
                            cnt_next   = '0;
                            clr_blk    = 1'b1;
                            err_next   = STATUS_OVF;
                            state_next = ST_ERR;
                        end
                    end else begin
                        inj_vld    = 1'b1;
                        cnt_next   = cnt_reg + CNT_W'(1);
                        eob_next   = s_tlast;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (done_now) begin
                    state_next = ST_IDLE;
                    if (eob_reg) begin
                        clr_blk  = 1'b1;
                        cnt_next = '0;
                        // a value coming to rest now is itself left over
                        if (store_now || any_pend) begin
                            err_next   = STATUS_LEN;
                            state_next = ST_ERR;
                        end
                    end
                end
            end
            ST_ERR: begin
                if (adv) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            eob_reg   <= 1'b0;
            err_reg   <= STATUS_OK;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            eob_reg   <= eob_next;
            err_reg   <= err_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // result select: at most one of detail, approximation, error per cycle
    always_comb begin
        res_vld    = 1'b0;
        res_coef   = '0;
        res_lvl    = l_eff;
        res_det    = 1'b0;
        res_pos    = '0;
        res_status = STATUS_OK;
        res_last   = 1'b1;
        for (int k = 0; k < MAX_LEVELS; k++) begin
            if (tok_out[k].vld) begin
                res_vld  = 1'b1;
                res_coef = det_coef[k];
                res_lvl  = LVL_W'(k + 1);
                res_det  = 1'b1;
                res_pos  = tok_out[k].pos;
                // last only if the next level just keeps the value and no error follows
                res_last = !lvl_last[k] && !pend_ext[k+1] && !eob_reg;
            end
        end
        if (apx_vld_reg) begin
            res_vld  = 1'b1;
            res_coef = apx_val_reg;
            res_pos  = apx_pos_reg;
            res_last = !eob_reg || !any_pend;
        end
        if (state_reg == ST_ERR) begin
            res_vld    = 1'b1;
            res_status = err_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (adv) begin
            m_vld_reg <= res_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= M_TDATA_W'({res_pos, res_lvl, res_coef});
            m_user_reg <= {res_status, res_det};
            m_last_reg <= res_last;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // only one sample in flight along the chain
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({in_vld_v, apx_vld_reg}))
        else $error("more than one value in flight");

    // idle means the chain is empty
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!(|in_vld_v) && !apx_vld_reg))
        else $error("idle with a value in the chain");

    // error words carry a zero coefficient and close the run
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:1] != STATUS_OK)) |->
        (m_tdata[COEF_W-1:0] == '0) && m_tlast && !m_tuser[0])
        else $error("malformed error word");

    // sample counter saturates one above the block limit
    a_cnt_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LIMIT + CNT_W'(1))
        else $error("sample counter beyond saturation");

    // no value reaches a cell past the configured depth
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |=> ((in_vld_v & ~((lvl_last << 1) - 1'b1 | lvl_last)) == '0))
        else $error("value beyond last level");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the multilevel haar wavelet block
// ----------------------------------------------------------------------------
// Samples go in through a bursty stream source, and result words are taken by
// a sink that stalls at random. Each accepted sample is run through a local
// model of the level chain, in orthogonal and integer lifting modes. Every
// result word is checked field by field against the oldest word the model
// queued. Phases cover directed extremes, random blocks at many level
// settings, a level change inside an open block, and a stale level left over
// from a wider setting at full rate.
// ----------------------------------------------------------------------------
module tb;

    import mhw_pkg::*;

    localparam int BLOCK_MAX   = 1 << MAX_BLOCK_LOG2;
    localparam int DRAIN       = MAX_LEVELS + 4;   // chain walk plus error word
    localparam int CYCLE_LIMIT = 2000000;
    localparam int REPORT_CAP  = 200;
    localparam int N_PHASES    = 11;

    // one sample word as queued for the source
    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] smp;
        logic                    eob;
    } sample_word_t;

    // one result word as the model predicts it
    typedef struct packed {
        logic [COEF_W-1:0]   coef;
        logic [LVL_W-1:0]    lvl;
        logic                det;
        logic [POS_W-1:0]    pos;
        logic [STATUS_W-1:0] status;
        logic                is_last;
    } coef_word_t;

    // dut ports, inputs known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    // stimulus and expectations
    sample_word_t sample_q[$];
    coef_word_t   coef_q[$];
    int           errors = 0;
    int           cycles = 0;
    bit           idle_on = 1'b1;   // random gaps and stalls enabled

    // model state: configuration mirror and per-level pending values
    logic [3:0]   cfg_levels = 4'd1;
    logic         cfg_int    = 1'b0;
    longint       lvl_pend[MAX_LEVELS];
    bit           lvl_full[MAX_LEVELS];
    int           blk_cnt = 0;
    coef_word_t   held_word;
    bit           have_word = 1'b0;

    // source and sink pacing
    sample_word_t nxt;
    int           burst_left = 0;
    int           gap_left   = 0;
    int           ready_left = 0;
    bit           stalled    = 1'b0;
    coef_word_t   want;

    // random level settings, with out-of-range values and odd mode bits
    logic [3:0] phase_lv[N_PHASES] = '{4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd8,
                                       4'd15, 4'd6, 4'd1, 4'd9, 4'd7};
    logic [3:0] phase_im[N_PHASES] = '{4'h1, 4'h0, 4'h1, 4'hE, 4'h1, 4'h0,
                                       4'h1, 4'h0, 4'h3, 4'h1, 4'h0};

    multilevel_haar_wavelet_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // sample[15:0]
        .s_tlast   (s_tlast),      // end_of_block
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // coefficient[23:0], level[27:24], position[43:28]
        .m_tuser   (m_tuser),      // is_detail[0], status[2:1]
        .m_tlast   (m_tlast)       // last_of_run
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // arithmetic of the level chain
    // ------------------------------------------------------------------

    function automatic longint clamp_coef(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // times 1/sqrt2 in q1.15, round to nearest with ties upward
    function automatic longint q15_round(input longint v);
        return (v * INV_SQRT2_Q15 + 16384) >>> 15;
    endfunction

    // words of one step are held back by one so the final one gets tlast
    function automatic void queue_word(input longint coef, input int lvl, input logic det,
                                       input int pos, input logic [STATUS_W-1:0] status);
        if (have_word) coef_q = {coef_q, held_word};
        held_word.coef    = coef[COEF_W-1:0];
        held_word.lvl     = lvl[LVL_W-1:0];
        held_word.det     = det;
        held_word.pos     = pos[POS_W-1:0];
        held_word.status  = status;
        held_word.is_last = 1'b0;
        have_word = 1'b1;
    endfunction

    // one accepted sample through the chain of levels
    function automatic void haar_predict(input logic signed [SAMPLE_WIDTH-1:0] smp,
                                         input logic eob);
        int     eff;
        int     k;
        int     idx;
        longint x;
        longint x0;
        longint a;
        longint d;
        bit     rested;
        bit     left;
        eff = (cfg_levels == 0) ? 1 :
              ((cfg_levels > MAX_LEVELS) ? MAX_LEVELS : int'(cfg_levels));
        x = smp;
        if (blk_cnt >= BLOCK_MAX) begin
            // block too long, sample dropped and overflow marked
            blk_cnt = BLOCK_MAX + 1;
        end else begin
            idx = blk_cnt;
            blk_cnt++;
            rested = 1'b0;
            k = 0;
            while (k < eff && !rested) begin
                if (!lvl_full[k]) begin
                    lvl_pend[k] = x;
                    lvl_full[k] = 1'b1;
                    rested = 1'b1;
                end else begin
                    x0 = lvl_pend[k];
                    if (cfg_int) begin
                        d = x - x0;
                        a = clamp_coef(x0 + (d >>> 1));
                        d = clamp_coef(d);
                    end else begin
                        a = clamp_coef(q15_round(x0 + x));
                        d = clamp_coef(q15_round(x - x0));
                    end
                    queue_word(d, k + 1, 1'b1, idx >> (k + 1), STATUS_OK);
                    lvl_full[k] = 1'b0;
                    lvl_pend[k] = 0;
                    x = a;
                    k++;
                end
            end
            // ran through every level: final approximation
            if (!rested) queue_word(x, eff, 1'b0, idx >> eff, STATUS_OK);
        end
        if (eob) begin
            // stale values at levels no longer in use count as well
            left = 1'b0;
            for (k = 0; k < MAX_LEVELS; k++)
                if (lvl_full[k]) left = 1'b1;
            if (blk_cnt > BLOCK_MAX)
                queue_word(0, eff, 1'b0, 0, STATUS_OVF);
            else if (left)
                queue_word(0, eff, 1'b0, 0, STATUS_LEN);
            for (k = 0; k < MAX_LEVELS; k++) begin
                lvl_full[k] = 1'b0;
                lvl_pend[k] = 0;
            end
            blk_cnt = 0;
        end
        if (have_word) begin
            held_word.is_last = 1'b1;
            coef_q = {coef_q, held_word};
            have_word = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [COEF_W-1:0] exp_v,
                                        input logic [COEF_W-1:0] act_v);
        if (exp_v !== act_v) begin
            if (errors < REPORT_CAP)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // sample source: bursts of random length with random gaps
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // the word on the bus goes into the model when it is taken
            if (s_tvalid && s_tready)
                haar_predict(s_tdata[SAMPLE_WIDTH-1:0], s_tlast);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    nxt = sample_q.pop_front();
                    s_tdata  <= nxt.smp;
                    s_tlast  <= nxt.eob;
                    s_tvalid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = ($urandom_range(0, 7) == 0) ?
                                     $urandom_range(40, 120) : $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0 && idle_on)
                        gap_left = $urandom_range(1, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result sink: checks each word and stalls on its own pattern
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (coef_q.size() == 0) begin
                    if (errors < REPORT_CAP)
                        $display("%0t ns: unexpected result, expected none, actual %h / %h",
                                 $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = coef_q.pop_front();
                    check_field("coefficient", want.coef, m_tdata[COEF_W-1:0]);
                    check_field("level", want.lvl, m_tdata[COEF_W+LVL_W-1:COEF_W]);
                    check_field("position", want.pos,
                                m_tdata[COEF_W+LVL_W+POS_W-1:COEF_W+LVL_W]);
                    check_field("is_detail", want.det, m_tuser[0]);
                    check_field("status", want.status, m_tuser[STATUS_W:1]);
                    check_field("last_of_run", want.is_last, m_tlast);
                end
            end
            if (!idle_on) begin
                m_tready <= 1'b1;
            end else begin
                // alternating ready and stall runs, now and then a long ready run
                if (ready_left == 0) begin
                    stalled = !stalled;
                    if (stalled)
                        ready_left = $urandom_range(1, 6);
                    else
                        ready_left = ($urandom_range(0, 5) == 0) ?
                                     $urandom_range(50, 150) : $urandom_range(1, 20);
                end
                ready_left--;
                m_tready <= !stalled;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL multilevel_haar_wavelet_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // write one register, only with the block idle
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [3:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_LEVELS)
            cfg_levels = val;
        else
            cfg_int = val[0];
        @(negedge aclk);
    endtask

    // wait until every word is out, then let a resting sample finish its walk
    task automatic settle();
        do @(negedge aclk);
        while (sample_q.size() != 0 || s_tvalid || coef_q.size() != 0);
        repeat (DRAIN) @(negedge aclk);
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return SAMPLE_WIDTH'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_sample(input logic [SAMPLE_WIDTH-1:0] v, input logic eob);
        sample_word_t w;
        w.smp = v;
        w.eob = eob;
        sample_q = {sample_q, w};
    endtask

    task automatic push_block(input int len, input bit with_eob);
        for (int i = 0; i < len; i++)
            push_sample(rand_sample(), with_eob && (i == len - 1));
    endtask

    // one setting: mostly whole blocks, some short or open ones
    task automatic run_phase(input logic [3:0] lv, input logic [3:0] im, input int budget,
                             input bit deep_ok);
        int eff;
        int unit;
        int n;
        int r;
        int len;
        write_reg(REG_LEVELS, lv);
        write_reg(REG_INT_MODE, im);
        eff  = (lv == 0) ? 1 : ((lv > MAX_LEVELS) ? MAX_LEVELS : int'(lv));
        unit = 1 << eff;
        n    = 0;
        while (n < budget) begin
            r = $urandom_range(0, 9);
            if (r == 9) begin
                // open run, merges into the next block
                len = $urandom_range(1, 5);
                push_block(len, 1'b0);
            end else begin
                if (r < 7 && (unit <= 32 || deep_ok))
                    len = unit * ((unit >= 16) ? 1 : $urandom_range(1, 16 / unit));
                else
                    len = $urandom_range(1, ((unit > 16) ? 16 : unit) + 3);
                push_block(len, 1'b1);
            end
            n += len;
        end
        // leave a block open now and then, so the next setting lands mid-block
        if ($urandom_range(0, 1)) push_block($urandom_range(1, 3), 1'b0);
        settle();
    endtask

    initial begin
        for (int k = 0; k < MAX_LEVELS; k++) begin
            lvl_pend[k] = 0;
            lvl_full[k] = 1'b0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset setting: one level, orthogonal; extreme pairs
        push_sample(16'h7FFF, 1'b0); push_sample(16'h7FFF, 1'b1);
        push_sample(16'h8000, 1'b0); push_sample(16'h8000, 1'b1);
        push_sample(16'h8000, 1'b0); push_sample(16'h7FFF, 1'b1);
        push_sample(16'h7FFF, 1'b0); push_sample(16'h8000, 1'b1);
        // single-sample block and odd block: length error
        push_sample(16'h0000, 1'b1);
        push_sample(16'hFFFF, 1'b0); push_sample(16'h0001, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        settle();

        // integer lifting over two levels, extremes and an odd block
        write_reg(REG_LEVELS, 4'd2);
        write_reg(REG_INT_MODE, 4'd1);
        push_sample(16'h7FFF, 1'b0); push_sample(16'h8000, 1'b0);
        push_sample(16'h8000, 1'b0); push_sample(16'h7FFF, 1'b1);
        push_sample(16'h8000, 1'b0); push_sample(16'h7FFF, 1'b0);
        push_sample(16'hFFFF, 1'b0); push_sample(16'h0000, 1'b0);
        push_sample(16'h0005, 1'b1);
        settle();

        // levels lowered inside an open block: stale value at level 2
        write_reg(REG_LEVELS, 4'd3);
        write_reg(REG_INT_MODE, 4'd0);
        push_sample(16'h1234, 1'b0); push_sample(16'hEDCB, 1'b0);
        push_sample(16'h0100, 1'b0);
        settle();
        write_reg(REG_LEVELS, 4'd1);
        push_sample(16'h7FFF, 1'b0); push_sample(16'h8000, 1'b1);
        settle();

        // random blocks over many settings, the deep one only at eight levels
        for (int p = 0; p < N_PHASES; p++)
            run_phase(phase_lv[p], phase_im[p], 20, phase_lv[p] == 4'd8);

        // full rate, with a stale level left from a wider setting
        idle_on = 1'b0;
        write_reg(REG_LEVELS, 4'd8);
        push_block(3, 1'b0);
        settle();
        write_reg(REG_LEVELS, 4'd1);
        push_block(16, 1'b1);
        settle();

        if (errors == 0)
            $display("PASS multilevel_haar_wavelet_top");
        else
            $display("FAIL multilevel_haar_wavelet_top");
        $finish;
    end

endmodule
